>>> rtl/core/fpa_pkg.sv
// fixed-point alu package: operation codes, port width and the sideband struct
// shared by the front stages, the divider pipeline and the top level
// no dependencies
package fpa_pkg;

  localparam int PORT_W = 32;
  localparam int OP_W   = 4;

  typedef logic [OP_W-1:0] op_t;

  localparam op_t OP_ADD      = 4'd0;
  localparam op_t OP_SUB      = 4'd1;
  localparam op_t OP_MUL      = 4'd2;
  localparam op_t OP_DIV      = 4'd3;
  localparam op_t OP_CMP      = 4'd4;
  localparam op_t OP_MIN      = 4'd5;
  localparam op_t OP_MAX      = 4'd6;
  localparam op_t OP_INC      = 4'd7;
  localparam op_t OP_DEC      = 4'd8;
  localparam op_t OP_FROM_INT = 4'd9;
  localparam op_t OP_TO_INT   = 4'd10;

  // control that travels with each item down the pipeline
  typedef struct packed {
    logic valid;
    logic is_div;
    logic div_zero;
    logic a_greater;
    logic a_less;
    logic a_equal;
  } side_t;

endpackage

>>> rtl/core/fpa_front.sv
// front end of the fixed-point alu: input register, operand decode with
// multiplier, product truncation and divider operand setup (three stages)
// depends on fpa_pkg
module fpa_front #(
  parameter int FRACTION_BITS = 8,
  parameter int WORD_WIDTH    = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  fpa_pkg::op_t                        operation_i,
  input  logic signed [fpa_pkg::PORT_W-1:0]   operand_a_i,
  input  logic signed [fpa_pkg::PORT_W-1:0]   operand_b_i,
  output fpa_pkg::side_t                      side_o,
  output logic signed [WORD_WIDTH-1:0]        word_o,
  output logic [WORD_WIDTH+FRACTION_BITS-1:0] dividend_o,
  output logic [WORD_WIDTH-1:0]               divisor_o,
  output logic                                neg_o
);

  localparam int W = WORD_WIDTH;
  localparam int F = FRACTION_BITS;
  localparam logic signed [W-1:0]   One     = {{(W-1){1'b0}}, 1'b1};
  localparam logic signed [2*W-1:0] MulBias = {{(2*W-F){1'b0}}, {F{1'b1}}};

  // stage 1: captured operands
  logic                v1_q;
  fpa_pkg::op_t        op1_q;
  logic signed [W-1:0] a1_q, b1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op1_q <= operation_i;
      a1_q  <= operand_a_i[W-1:0];
      b1_q  <= operand_b_i[W-1:0];
    end
  end

  // stage 2: simple results, flags, product, magnitudes
  fpa_pkg::side_t        side2_d, side2_q;
  logic                  mul2_d, mul2_q;
  logic signed [W-1:0]   simple2_d, simple2_q;
  logic signed [2*W-1:0] prod2_d, prod2_q;
  logic [W-1:0]          amag2_d, amag2_q, bmag2_d, bmag2_q;
  logic                  neg2_d, neg2_q;

  always_comb begin
    unique case (op1_q)
      fpa_pkg::OP_ADD:      simple2_d = a1_q + b1_q;
      fpa_pkg::OP_SUB:      simple2_d = a1_q - b1_q;
      fpa_pkg::OP_MIN:      simple2_d = (a1_q <= b1_q) ? a1_q : b1_q;
      fpa_pkg::OP_MAX:      simple2_d = (a1_q >= b1_q) ? a1_q : b1_q;
      fpa_pkg::OP_INC:      simple2_d = a1_q + One;
      fpa_pkg::OP_DEC:      simple2_d = a1_q - One;
      fpa_pkg::OP_FROM_INT: simple2_d = a1_q <<< F;
      fpa_pkg::OP_TO_INT:   simple2_d = a1_q >>> F;
      default:              simple2_d = '0;
    endcase
  end

  always_comb begin
    side2_d.valid     = v1_q;
    side2_d.is_div    = (op1_q == fpa_pkg::OP_DIV);
    side2_d.div_zero  = (op1_q == fpa_pkg::OP_DIV) && (b1_q == '0);
    side2_d.a_greater = (a1_q > b1_q);
    side2_d.a_less    = (a1_q < b1_q);
    side2_d.a_equal   = (a1_q == b1_q);
    mul2_d            = (op1_q == fpa_pkg::OP_MUL);
    prod2_d           = a1_q * b1_q;
    // magnitude of the most negative word still fits as unsigned
    amag2_d           = a1_q[W-1] ? (~a1_q + One) : a1_q;
    bmag2_d           = b1_q[W-1] ? (~b1_q + One) : b1_q;
    neg2_d            = a1_q[W-1] ^ b1_q[W-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side2_q <= '0;
    end else if (en_i) begin
      side2_q <= side2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mul2_q    <= mul2_d;
      simple2_q <= simple2_d;
      prod2_q   <= prod2_d;
      amag2_q   <= amag2_d;
      bmag2_q   <= bmag2_d;
      neg2_q    <= neg2_d;
    end
  end

  // stage 3: product truncated toward zero, merged with the simple result
  fpa_pkg::side_t        side3_q;
  logic signed [2*W-1:0] mul_sum;
  logic signed [W-1:0]   word3_d, word3_q;
  logic [W+F-1:0]        dividend3_q;
  logic [W-1:0]          divisor3_q;
  logic                  neg3_q;

  always_comb begin
    mul_sum = prod2_q + (prod2_q[2*W-1] ? MulBias : '0);
    word3_d = mul2_q ? mul_sum[F+W-1:F] : simple2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side3_q <= '0;
    end else if (en_i) begin
      side3_q <= side2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      word3_q     <= word3_d;
      dividend3_q <= {amag2_q, {F{1'b0}}};
      divisor3_q  <= bmag2_q;
      neg3_q      <= neg2_q;
    end
  end

  assign side_o     = side3_q;
  assign word_o     = word3_q;
  assign dividend_o = dividend3_q;
  assign divisor_o  = divisor3_q;
  assign neg_o      = neg3_q;

endmodule

>>> rtl/core/fpa_div.sv
// pipelined restoring divider for the fixed-point alu: one quotient bit per
// stage on unsigned magnitudes, sideband and merged result ride alongside
// depends on fpa_pkg
module fpa_div #(
  parameter int FRACTION_BITS = 8,
  parameter int WORD_WIDTH    = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  fpa_pkg::side_t                      side_i,
  input  logic signed [WORD_WIDTH-1:0]        word_i,
  input  logic [WORD_WIDTH+FRACTION_BITS-1:0] dividend_i,
  input  logic [WORD_WIDTH-1:0]               divisor_i,
  input  logic                                neg_i,
  output fpa_pkg::side_t                      side_o,
  output logic signed [WORD_WIDTH-1:0]        word_o,
  output logic [WORD_WIDTH+FRACTION_BITS-1:0] quot_o,
  output logic                                neg_o
);

  localparam int W = WORD_WIDTH;
  localparam int N = WORD_WIDTH + FRACTION_BITS;

  fpa_pkg::side_t      side_q [N];
  logic signed [W-1:0] word_q [N];
  logic [W-1:0]        rem_q  [N];
  logic [N-1:0]        dq_q   [N];
  logic [W-1:0]        dvs_q  [N];
  logic                neg_q  [N];

  for (genvar s = 0; s < N; s++) begin : g_step
    fpa_pkg::side_t      side_in;
    logic signed [W-1:0] word_in;
    logic [W-1:0]        rem_in, dvs_in, rem_d;
    logic [N-1:0]        dq_in, dq_d;
    logic                neg_in;
    logic [W:0]          trial;
    logic [W+1:0]        diff;
    logic                ge;

    if (s == 0) begin : g_first
      assign side_in = side_i;
      assign word_in = word_i;
      assign rem_in  = '0;
      assign dq_in   = dividend_i;
      assign dvs_in  = divisor_i;
      assign neg_in  = neg_i;
    end else begin : g_next
      assign side_in = side_q[s-1];
      assign word_in = word_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign dq_in   = dq_q[s-1];
      assign dvs_in  = dvs_q[s-1];
      assign neg_in  = neg_q[s-1];
    end

    // shift in the next dividend bit, subtract if it fits
    always_comb begin
      trial = {rem_in, dq_in[N-1]};
      diff  = {1'b0, trial} - {2'b00, dvs_in};
      ge    = ~diff[W+1];
      rem_d = ge ? diff[W-1:0] : trial[W-1:0];
      dq_d  = {dq_in[N-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        side_q[s] <= '0;
      end else if (en_i) begin
        side_q[s] <= side_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        word_q[s] <= word_in;
        rem_q[s]  <= rem_d;
        dq_q[s]   <= dq_d;
        dvs_q[s]  <= dvs_in;
        neg_q[s]  <= neg_in;
      end
    end
  end

  assign side_o = side_q[N-1];
  assign word_o = word_q[N-1];
  assign quot_o = dq_q[N-1];
  assign neg_o  = neg_q[N-1];

endmodule

>>> rtl/core/fpa_skid.sv
// two-entry output buffer for the fixed-point alu; full is registered so the
// pipeline enable does not depend on the downstream ready
// no dependencies
module fpa_skid #(
  parameter int DATA_W = 36
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] data_i,
  output logic              full_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DATA_W-1:0] data_o
);

  logic [DATA_W-1:0] entry_q [2];
  logic              wr_ptr_q, rd_ptr_q;
  logic [1:0]        count_q, count_d;
  logic              pop;

  assign pop         = out_valid_o & out_ready_i;
  assign out_valid_o = (count_q != 2'd0);
  assign full_o      = (count_q == 2'd2);
  assign data_o      = entry_q[rd_ptr_q];

  always_comb begin
    case ({push_i, pop})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> rtl/core/fixed_point_alu_unit.sv
// Signed fixed-point ALU on raw words with FRACTION_BITS fraction bits (Q24.8 by
// default). One transaction enters per cycle while in_ready_o is high and each
// gives exactly one result, in order. Every operation takes the same path
// through the pipeline: three front stages (input, decode/multiply, product
// truncation) are followed by a restoring divider that resolves one quotient
// bit per stage, and its WORD_WIDTH + FRACTION_BITS stages set the depth. The
// last stage feeds a two-entry output buffer; in_ready_o drops only while that
// buffer is full, and the whole pipeline then holds in place.
// depends on fpa_pkg, fpa_front, fpa_div, fpa_skid
module fixed_point_alu_unit #(
  parameter int FRACTION_BITS = 8,
  parameter int WORD_WIDTH    = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [fpa_pkg::OP_W-1:0]          operation_i,
  input  logic signed [fpa_pkg::PORT_W-1:0] operand_a_i,
  input  logic signed [fpa_pkg::PORT_W-1:0] operand_b_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [fpa_pkg::PORT_W-1:0] result_word_o,
  output logic                              a_greater_o,
  output logic                              a_less_o,
  output logic                              a_equal_o,
  output logic                              divide_by_zero_o
);

  localparam int W     = WORD_WIDTH;
  localparam int N     = WORD_WIDTH + FRACTION_BITS;
  localparam int PortW = fpa_pkg::PORT_W;
  localparam int OutW  = PortW + 4;

  logic                en;
  logic                full;

  fpa_pkg::side_t      front_side, div_side;
  logic signed [W-1:0] front_word, div_word;
  logic [N-1:0]        front_dividend, quot;
  logic [W-1:0]        front_divisor;
  logic                front_neg, div_neg;

  logic signed [W-1:0] qword, final_word;
  logic [OutW-1:0]     out_data_d, out_data;

  assign en         = ~full;
  assign in_ready_o = ~full;

  fpa_front #(
    .FRACTION_BITS (FRACTION_BITS),
    .WORD_WIDTH    (WORD_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (in_valid_i),
    .operation_i (operation_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .side_o      (front_side),
    .word_o      (front_word),
    .dividend_o  (front_dividend),
    .divisor_o   (front_divisor),
    .neg_o       (front_neg)
  );

  fpa_div #(
    .FRACTION_BITS (FRACTION_BITS),
    .WORD_WIDTH    (WORD_WIDTH)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .side_i     (front_side),
    .word_i     (front_word),
    .dividend_i (front_dividend),
    .divisor_i  (front_divisor),
    .neg_i      (front_neg),
    .side_o     (div_side),
    .word_o     (div_word),
    .quot_o     (quot),
    .neg_o      (div_neg)
  );

  // signed quotient wraps to the low word bits; zero divisor forces zero
  always_comb begin
    qword = quot[W-1:0];
    if (div_side.is_div) begin
      if (div_side.div_zero) begin
        final_word = '0;
      end else begin
        final_word = div_neg ? -qword : qword;
      end
    end else begin
      final_word = div_word;
    end
    out_data_d = {PortW'(final_word), div_side.a_greater, div_side.a_less,
                  div_side.a_equal, div_side.div_zero};
  end

  fpa_skid #(
    .DATA_W (OutW)
  ) u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (en & div_side.valid),
    .data_i      (out_data_d),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .data_o      (out_data)
  );

  assign result_word_o    = out_data[OutW-1:4];
  assign a_greater_o      = out_data[3];
  assign a_less_o         = out_data[2];
  assign a_equal_o        = out_data[1];
  assign divide_by_zero_o = out_data[0];

endmodule
